### sv/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg: shared types and constants of the nearest palette color search
// Item and score structs, the palette size, and the built-in palette table
// that every palette cell loads as its reset value.
// ----------------------------------------------------------------------------
`default_nettype none

package npcs_pkg;

  localparam int unsigned PALETTE_ENTRIES = 256;

  localparam int unsigned IdxW  = 8;
  localparam int unsigned CompW = 8;
  localparam int unsigned DistW = 18;

  localparam int unsigned CubeStep    = 51;
  localparam int unsigned CubeLevels  = 6;
  localparam int unsigned CubeEntries = 216;
  localparam int unsigned BlackLast   = 222;
  localparam int unsigned GrayFirst   = 223;
  localparam int unsigned WhiteIndex  = 255;
  localparam int unsigned GrayStep    = 8;
  localparam int unsigned GrayCount   = WhiteIndex - GrayFirst;

  // Largest distance that any real entry can produce.
  localparam logic [DistW-1:0] MaxRealDist = DistW'(195075);

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Entry layout: red in the top byte, blue in the low byte.
  typedef logic [3*CompW-1:0] rgb_t;
  typedef rgb_t [255:0] palette_t;

  typedef struct packed {
    op_e              op;
    logic [IdxW-1:0]  idx;
    logic [CompW-1:0] red;
    logic [CompW-1:0] green;
    logic [CompW-1:0] blue;
  } item_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic [IdxW-1:0]  idx;
  } score_t;

  function automatic palette_t builtin_palette();
    palette_t p;
    int       n;
    p = '0;
    n = 0;
    for (int t = 0; t < CubeLevels; t++) begin
      for (int m = 0; m < CubeLevels; m++) begin
        for (int l = 0; l < CubeLevels; l++) begin
          p[n] = {CompW'(l * CubeStep), CompW'(m * CubeStep), CompW'(t * CubeStep)};
          n++;
        end
      end
    end
    for (int b = CubeEntries; b <= BlackLast; b++) begin
      p[b] = '0;
    end
    for (int k = 0; k < GrayCount; k++) begin
      p[GrayFirst + k] = {3{CompW'(k * GrayStep)}};
    end
    p[WhiteIndex] = '1;
    return p;
  endfunction

  localparam palette_t BUILTIN_PALETTE = builtin_palette();

endpackage

`default_nettype wire

### sv/npcs_cell.sv
// ----------------------------------------------------------------------------
// npcs_cell: one palette cell of the search chain
// Holds one palette entry, takes loads addressed to it, scores each passing
// query against its entry and folds the previous cell's score into the best.
// ----------------------------------------------------------------------------
`default_nettype none

module npcs_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [npcs_pkg::IdxW-1:0] cell_idx_i,
  input  logic                   valid_i,
  input  npcs_pkg::item_t        item_i,
  input  npcs_pkg::score_t       best_i,
  input  npcs_pkg::score_t       cand_i,
  output logic                   valid_o,
  output npcs_pkg::item_t        item_o,
  output npcs_pkg::score_t       best_o,
  output npcs_pkg::score_t       cand_o
);
  import npcs_pkg::*;

  rgb_t             entry_q;
  logic             valid_q;
  item_t            item_q;
  score_t           best_q, best_d;
  score_t           cand_q, cand_d;
  logic [CompW-1:0] ent_r, ent_g, ent_b;
  logic [CompW-1:0] dr, dg, db;
  logic [2*CompW-1:0] sr, sg, sb;
  logic             load_hit;

  assign {ent_r, ent_g, ent_b} = entry_q;

  always_comb begin
    dr = (item_i.red   >= ent_r) ? item_i.red   - ent_r : ent_r - item_i.red;
    dg = (item_i.green >= ent_g) ? item_i.green - ent_g : ent_g - item_i.green;
    db = (item_i.blue  >= ent_b) ? item_i.blue  - ent_b : ent_b - item_i.blue;
    sr = dr * dr;
    sg = dg * dg;
    sb = db * db;
    cand_d.distance = DistW'(sr) + DistW'(sg) + DistW'(sb);
    cand_d.idx      = cell_idx_i;
    // The previous cell's candidate has a higher index, so it wins only when
    // strictly closer.
    best_d = (cand_i.distance < best_i.distance) ? cand_i : best_i;
  end

  assign load_hit = en_i && valid_i && (item_i.op == OP_LOAD) && (item_i.idx == cell_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= BUILTIN_PALETTE[cell_idx_i];
    end else if (load_hit) begin
      entry_q <= {item_i.red, item_i.green, item_i.blue};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_i;
      best_q <= best_d;
      cand_q <= cand_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign best_o  = best_q;
  assign cand_o  = cand_q;

endmodule

`default_nettype wire

### sv/nearest_palette_color_search.sv
// Each query passes the chain of palette cells and then the output register.
// Throughput: one item per cycle while no result waits; loads and queries
// share the chain in order.
// Reset: asynchronous, active low; the palette returns to the built-in set
// and all items in flight are dropped.
// ----------------------------------------------------------------------------
// nearest_palette_color_search: nearest palette entry for a pixel
// Items walk a row of palette cells, one cell a cycle unless a result waits. Each cell keeps one
// entry; a final compare picks the entry with the smallest squared distance.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_search (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [npcs_pkg::IdxW-1:0]   entry_index_i,
  input  logic [npcs_pkg::CompW-1:0]  red_i,
  input  logic [npcs_pkg::CompW-1:0]  green_i,
  input  logic [npcs_pkg::CompW-1:0]  blue_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [npcs_pkg::IdxW-1:0]   best_index_o,
  output logic [npcs_pkg::DistW-1:0]  best_distance_o
);
  import npcs_pkg::*;

  localparam int unsigned N = PALETTE_ENTRIES;

  logic   adv;
  logic   valid_c [0:N];
  item_t  item_c  [0:N];
  score_t best_c  [0:N];
  score_t cand_c  [0:N];

  logic                 out_valid_q, out_valid_d;
  logic [IdxW-1:0]      best_index_q;
  logic [DistW-1:0]     best_distance_q;
  score_t               final_score;

  // The whole chain moves together; it holds only while a result waits.
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  assign valid_c[0] = in_valid_i;
  assign item_c[0]  = '{op: op_e'(op_i), idx: entry_index_i, red: red_i,
                        green: green_i, blue: blue_i};
  assign best_c[0]  = '{distance: '1, idx: '0};
  assign cand_c[0]  = '{distance: '1, idx: '0};

  for (genvar k = 0; k < N; k++) begin : g_cell
    npcs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (adv),
      .cell_idx_i (IdxW'(k)),
      .valid_i    (valid_c[k]),
      .item_i     (item_c[k]),
      .best_i     (best_c[k]),
      .cand_i     (cand_c[k]),
      .valid_o    (valid_c[k+1]),
      .item_o     (item_c[k+1]),
      .best_o     (best_c[k+1]),
      .cand_o     (cand_c[k+1])
    );
  end

  assign final_score = (cand_c[N].distance < best_c[N].distance) ? cand_c[N] : best_c[N];
  assign out_valid_d = valid_c[N] && (item_c[N].op == OP_QUERY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      best_index_q    <= final_score.idx;
      best_distance_q <= final_score.distance;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign best_index_o    = best_index_q;
  assign best_distance_o = best_distance_q;

  // A load leaving the chain never turns into a result.
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && valid_c[N] && (item_c[N].op == OP_LOAD)) |=> !out_valid_o)
    else $error("load item produced a result");

  // A result always refers to a real entry, never the chain's start marker.
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (best_distance_o <= MaxRealDist))
    else $error("result distance out of range");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(best_index_o) < N))
    else $error("result index beyond palette");

  // While the output stalls, the valid flags of the first and last cells may not move.
  a_chain_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(valid_c[N]) && $stable(valid_c[1])))
    else $error("chain moved during a stall");

endmodule

`default_nettype wire
